// ===== src/dspg_pkg.sv =====
// Package for the dual servo pulse generator.
// Holds operation, phase and register codes, reset values and shared structs.
// No dependencies.
package dspg_pkg;

	localparam int unsigned RELOAD_W = 16;
	localparam int unsigned POS_W    = 8;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_SET  = 2'd1,
		OP_ADD  = 2'd2,
		OP_SUB  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PH_GAP   = 2'd0,
		PH_LEFT  = 2'd1,
		PH_RIGHT = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		REG_MAX_POSITION = 2'd0,
		REG_FRAME_GAP    = 2'd1,
		REG_LEFT_BASE    = 2'd2,
		REG_RIGHT_BASE   = 2'd3
	} reg_idx_t;

	localparam logic [POS_W-1:0]    RST_MAX_POSITION = 8'd250;
	localparam logic [RELOAD_W-1:0] RST_FRAME_GAP    = 16'd50000;
	localparam logic [RELOAD_W-1:0] RST_LEFT_BASE    = 16'd2500;
	localparam logic [RELOAD_W-1:0] RST_RIGHT_BASE   = 16'd5000;
	localparam logic [POS_W-1:0]    RST_POSITION     = 8'd66;
	localparam logic [RELOAD_W-1:0] RST_TICKS        = 16'd16000;
	localparam logic [RELOAD_W-1:0] RELOAD_MIN       = 16'd1;
	localparam logic [RELOAD_W-1:0] RELOAD_MAX       = 16'hFFFF;

	typedef struct packed {
		logic [POS_W-1:0]    max_position;
		logic [RELOAD_W-1:0] frame_gap;
		logic [RELOAD_W-1:0] left_base;
		logic [RELOAD_W-1:0] right_base;
	} cfg_t;

	typedef struct packed {
		logic             left_pin;
		logic             right_pin;
		logic [POS_W-1:0] position;
		logic             clamped;
	} res_t;

endpackage

// ===== src/dspg_apb_regs.sv =====
// APB register file for the servo pulse generator configuration.
// Depends on dspg_pkg for register codes, reset values and cfg_t.
module dspg_apb_regs import dspg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_position <= RST_MAX_POSITION;
			cfg_q.frame_gap    <= RST_FRAME_GAP;
			cfg_q.left_base    <= RST_LEFT_BASE;
			cfg_q.right_base   <= RST_RIGHT_BASE;
		end else if (wr_en) begin
			case (idx)
				REG_MAX_POSITION: cfg_q.max_position <= pwdata[POS_W-1:0];
				REG_FRAME_GAP:    cfg_q.frame_gap    <= pwdata[RELOAD_W-1:0];
				REG_LEFT_BASE:    cfg_q.left_base    <= pwdata[RELOAD_W-1:0];
				REG_RIGHT_BASE:   cfg_q.right_base   <= pwdata[RELOAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MAX_POSITION: prdata = {{(32-POS_W){1'b0}}, cfg_q.max_position};
			REG_FRAME_GAP:    prdata = {{(32-RELOAD_W){1'b0}}, cfg_q.frame_gap};
			REG_LEFT_BASE:    prdata = {{(32-RELOAD_W){1'b0}}, cfg_q.left_base};
			REG_RIGHT_BASE:   prdata = {{(32-RELOAD_W){1'b0}}, cfg_q.right_base};
			default:          prdata = '0;
		endcase
	end

endmodule

// ===== src/dspg_core.sv =====
// Servo state: position saturation, tick countdown and the three-phase frame.
// Depends on dspg_pkg. Computes the next state and result of one transaction.
module dspg_core import dspg_pkg::*; #(
	parameter int unsigned POSITION_SCALE = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  op_t              op,
	input  logic [POS_W-1:0] amt,
	input  cfg_t             cfg,
	output res_t             res
);

	localparam int unsigned SCALED_W = POS_W + $clog2(POSITION_SCALE + 1);
	localparam int unsigned SUM_W    = RELOAD_W + 1;

	phase_t              phase_q, phase_d;
	logic [RELOAD_W-1:0] ticks_q, ticks_d;
	logic [POS_W-1:0]    position_q, position_d;
	logic                left_q, left_d;
	logic                right_q, right_d;
	logic                clamped_d;

	logic [SCALED_W-1:0] scaled;
	logic [SUM_W-1:0]    scaled_x;
	logic [SUM_W-1:0]    left_sum;
	logic [RELOAD_W-1:0] left_reload;
	logic [RELOAD_W-1:0] right_reload;
	logic [RELOAD_W-1:0] gap_reload;
	logic [POS_W:0]      add_sum;

	assign scaled   = SCALED_W'(position_q) * SCALED_W'(POSITION_SCALE);
	assign scaled_x = SUM_W'(scaled);
	assign left_sum = {1'b0, cfg.left_base} + scaled_x;
	assign add_sum  = {1'b0, position_q} + {1'b0, amt};

	// clamp every reload to 1..65535
	always_comb begin
		if (left_sum[RELOAD_W])
			left_reload = RELOAD_MAX;
		else if (left_sum[RELOAD_W-1:0] == '0)
			left_reload = RELOAD_MIN;
		else
			left_reload = left_sum[RELOAD_W-1:0];

		if (scaled_x >= {1'b0, cfg.right_base})
			right_reload = RELOAD_MIN;
		else
			right_reload = cfg.right_base - scaled_x[RELOAD_W-1:0];

		gap_reload = (cfg.frame_gap == '0) ? RELOAD_MIN : cfg.frame_gap;
	end

	always_comb begin
		phase_d    = phase_q;
		ticks_d    = ticks_q;
		position_d = position_q;
		left_d     = left_q;
		right_d    = right_q;
		clamped_d  = 1'b0;
		case (op)
			OP_TICK: begin
				if (ticks_q <= RELOAD_MIN) begin
					case (phase_q)
						PH_GAP: begin
							left_d  = 1'b0;
							right_d = 1'b0;
							ticks_d = gap_reload;
							phase_d = PH_LEFT;
						end
						PH_LEFT: begin
							left_d  = 1'b1;
							right_d = 1'b0;
							ticks_d = left_reload;
							phase_d = PH_RIGHT;
						end
						default: begin
							left_d  = 1'b0;
							right_d = 1'b1;
							ticks_d = right_reload;
							phase_d = PH_GAP;
						end
					endcase
				end else begin
					ticks_d = ticks_q - RELOAD_MIN;
				end
			end
			OP_SET: begin
				if (amt > cfg.max_position) begin
					position_d = cfg.max_position;
					clamped_d  = 1'b1;
				end else begin
					position_d = amt;
				end
			end
			OP_ADD: begin
				if (add_sum > {1'b0, cfg.max_position}) begin
					position_d = cfg.max_position;
					clamped_d  = 1'b1;
				end else begin
					position_d = add_sum[POS_W-1:0];
				end
			end
			default: begin
				if (amt > position_q) begin
					position_d = '0;
					clamped_d  = 1'b1;
				end else begin
					position_d = position_q - amt;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_GAP;
			ticks_q    <= RST_TICKS;
			position_q <= RST_POSITION;
			left_q     <= 1'b0;
			right_q    <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			ticks_q    <= ticks_d;
			position_q <= position_d;
			left_q     <= left_d;
			right_q    <= right_d;
		end
	end

	assign res.left_pin  = left_d;
	assign res.right_pin = right_d;
	assign res.position  = position_d;
	assign res.clamped   = clamped_d;

endmodule

// ===== src/dual_servo_pulse_generator_core.sv =====
// Dual servo pulse generator, top level.
// Two register stages from input port to output port: the stage-1 input register
// and the result register. Throughput: one transaction per cycle while out_stall
// does not hold the result register; the state update is one short pass (tick
// decrement/compare or 8-bit saturating set, add or subtract) between the two.
// Reset: arst_n clears both stages, loads register defaults, position 66, countdown 16000.
// Depends on dspg_pkg, dspg_apb_regs and dspg_core.
module dual_servo_pulse_generator_core import dspg_pkg::*; #(
	parameter int unsigned POSITION_SCALE = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  amount,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        left_pin,
	output logic        right_pin,
	output logic [7:0]  position,
	output logic        clamped
);

	cfg_t             cfg;
	res_t             res;
	logic             valid_s1;
	op_t              op_s1;
	logic [POS_W-1:0] amt_s1;
	logic             out_valid_q;
	res_t             res_q;
	logic             advance;
	logic             accept;

	dspg_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// move the stage-1 transaction into the result register when it is free
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	dspg_core #(
		.POSITION_SCALE (POSITION_SCALE)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.op     (op_s1),
		.amt    (amt_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= op_t'(operation);
			amt_s1 <= amount;
		end
		if (advance)
			res_q <= res;
	end

	assign out_valid = out_valid_q;
	assign left_pin  = res_q.left_pin;
	assign right_pin = res_q.right_pin;
	assign position  = res_q.position;
	assign clamped   = res_q.clamped;

endmodule
